>>> sv/lgq_pkg.sv
// Shared types, codes and the lock-mode conflict table for the intent lock grant queue.
package lgq_pkg;

  localparam logic [1:0] K_LOCK   = 2'd0;
  localparam logic [1:0] K_UNLOCK = 2'd1;
  localparam logic [1:0] K_DOWN   = 2'd2;

  localparam logic [2:0] MODE_NONE = 3'd0;
  localparam logic [2:0] MODE_X    = 3'd4;
  localparam int         MODES     = 5;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_GRANTED = 2'd1;
  localparam logic [1:0] ST_WAITING = 2'd2;

  localparam logic [2:0] OUT_GRANTED    = 3'd0;
  localparam logic [2:0] OUT_WAITING    = 3'd1;
  localparam logic [2:0] OUT_RELEASED   = 3'd2;
  localparam logic [2:0] OUT_DOWNGRADED = 3'd3;
  localparam logic [2:0] OUT_REFUSED    = 3'd4;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] mode;
    logic       cf;
  } holder_t;

  typedef struct packed {
    logic       vld;
    logic [3:0] id;
    logic [2:0] outcome;
  } emit_t;

  typedef struct packed {
    logic out_free;
    logic pend_valid;
  } out_stat_t;

  // bit m set = conflicts with a holder of mode m
  function automatic logic [4:0] conflict_mask(input logic [2:0] m);
    logic [4:0] r;
    case (m)
      3'd1:    r = 5'h10;
      3'd2:    r = 5'h18;
      3'd3:    r = 5'h14;
      3'd4:    r = 5'h1E;
      default: r = 5'h00;
    endcase
    return r;
  endfunction

endpackage

>>> sv/lgq_holder_mem.sv
// Requester table memory with per-entry valid bits; an unwritten entry reads idle.
module lgq_holder_mem #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IW-1:0]    rd_addr,
  output lgq_pkg::holder_t rd_data,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_addr,
  input  lgq_pkg::holder_t wr_data
);

  lgq_pkg::holder_t mem [DEPTH];
  logic [DEPTH-1:0] vbits;
  lgq_pkg::holder_t raw;
  logic             raw_vld;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits   <= '0;
      raw_vld <= 1'b0;
    end else begin
      if (wr_en) vbits[wr_addr] <= 1'b1;
      if (rd_en) raw_vld <= vbits[rd_addr];
    end
  end

  assign rd_data = raw_vld ? raw : '0;

endmodule

>>> sv/lgq_queue_mem.sv
// Wait queue storage: requester ids in a circular buffer, one write and one read port.
module lgq_queue_mem #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [3:0]    rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [3:0]    wr_data
);

  logic [3:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/lgq_out_reg.sv
// Result holding stage plus output register; the held result learns its last flag late.
module lgq_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  lgq_pkg::emit_t     emit,
  input  logic               flush,
  output lgq_pkg::out_stat_t stat,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,  // [3:0] target_id, [6:4] outcome, [7] zero
  output logic               m_tlast
);

  logic       pend_valid;
  logic [3:0] pend_id;
  logic [2:0] pend_outcome;
  logic       out_free;

  assign out_free        = !m_tvalid || m_tready;
  assign stat.out_free   = out_free;
  assign stat.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (emit.vld) begin
        pend_valid <= 1'b1;
        m_tvalid   <= pend_valid || (m_tvalid && !m_tready);
      end else if (flush) begin
        pend_valid <= 1'b0;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit.vld) begin
      pend_id      <= emit.id;
      pend_outcome <= emit.outcome;
      if (pend_valid) begin
        m_tdata <= {1'b0, pend_outcome, pend_id};
        m_tlast <= 1'b0;
      end
    end else if (flush) begin
      m_tdata <= {1'b0, pend_outcome, pend_id};
      m_tlast <= 1'b1;
    end
  end

endmodule

>>> sv/intent_lock_grant_queue.sv
// Intent lock grant queue: lock head of one resource with IS/IX/S/X modes.
// Lock request: the holder entry is read in S_HOLD and the result is sent on from S_FIN; one at a time.
// Unlock/downgrade: queue entries are scanned one by one (S_QRD, S_QDAT, S_HDAT), then moved
// after the scan stops; a waiting unlock first runs a removal pass. The single-read holder and
// queue memories set the pace. Each result also waits while the output register is full.
// Reset clears counts, queue head and length and the table valid bits; there is no clearing pass.
module intent_lock_grant_queue #(
  parameter int REQUESTERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [3:0] requester_id, [6:4] mode, [7] to_front,
                                // [8] cf_holder, [15:9] zero
  input  logic [1:0]  s_tuser,  // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // [3:0] target_id, [6:4] outcome, [7] zero
  output logic        m_tlast
);

  localparam int IW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int CW = $clog2(REQUESTERS + 1);
  localparam int SW = CW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HOLD = 3'd1;
  localparam logic [2:0] S_QRD  = 3'd2;
  localparam logic [2:0] S_QDAT = 3'd3;
  localparam logic [2:0] S_HDAT = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]    state, state_next;
  logic [1:0]    kind_q, kind_next;
  logic [3:0]    id_q, id_next;
  logic [2:0]    mode_q, mode_next;
  logic          front_q, front_next;
  logic          cf_q, cf_next;
  logic [IW-1:0] head, head_next;
  logic [CW-1:0] qlen, qlen_next;
  logic [CW-1:0] grant [lgq_pkg::MODES];
  logic [CW-1:0] grant_next [lgq_pkg::MODES];
  logic [CW-1:0] waitc [lgq_pkg::MODES];
  logic [CW-1:0] waitc_next [lgq_pkg::MODES];
  logic [CW-1:0] cfh, cfh_next;
  logic [CW-1:0] r, r_next, w, w_next;
  logic          pass_rm, pass_rm_next;
  logic          copy, copy_next;
  logic          newly, newly_next;
  logic [3:0]    qid, qid_next;

  lgq_pkg::holder_t   h, hwr_data;
  logic               hrd_en, hwr_en;
  logic [IW-1:0]      hrd_addr, hwr_addr;
  logic               qrd_en, qwr_en;
  logic [IW-1:0]      qrd_addr, qwr_addr;
  logic [3:0]         qrd_data, qwr_data;
  lgq_pkg::emit_t     emit;
  logic               flush;
  lgq_pkg::out_stat_t ostat;

  logic [4:0] gmask, wmask;
  logic       mode_ok, accept;

  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base, input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(k);
    if (s >= SW'(REQUESTERS)) s = s - SW'(REQUESTERS);
    return IW'(s);
  endfunction

  always_comb begin
    for (int i = 0; i < lgq_pkg::MODES; i++) begin
      gmask[i] = grant[i] != '0;
      wmask[i] = waitc[i] != '0;
    end
  end

  assign mode_ok  = mode_q != lgq_pkg::MODE_NONE && mode_q <= lgq_pkg::MODE_X;
  assign s_tready = state == S_IDLE;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next   = state;
    kind_next    = kind_q;
    id_next      = id_q;
    mode_next    = mode_q;
    front_next   = front_q;
    cf_next      = cf_q;
    head_next    = head;
    qlen_next    = qlen;
    grant_next   = grant;
    waitc_next   = waitc;
    cfh_next     = cfh;
    r_next       = r;
    w_next       = w;
    pass_rm_next = pass_rm;
    copy_next    = copy;
    newly_next   = newly;
    qid_next     = qid;
    hrd_en       = 1'b0;
    hrd_addr     = IW'(id_q);
    hwr_en       = 1'b0;
    hwr_addr     = IW'(id_q);
    hwr_data     = h;
    qrd_en       = 1'b0;
    qrd_addr     = wrap(head, r);
    qwr_en       = 1'b0;
    qwr_addr     = wrap(head, w);
    qwr_data     = qrd_data;
    emit         = '0;
    emit.id      = id_q;
    flush        = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          kind_next  = s_tuser;
          id_next    = s_tdata[3:0];
          mode_next  = s_tdata[6:4];
          front_next = s_tdata[7];
          cf_next    = s_tdata[8];
          if (32'(s_tdata[3:0]) >= REQUESTERS) begin
            emit.vld     = 1'b1;
            emit.id      = s_tdata[3:0];
            emit.outcome = lgq_pkg::OUT_REFUSED;
            state_next   = S_FIN;
          end else begin
            hrd_en     = 1'b1;
            hrd_addr   = IW'(s_tdata[3:0]);
            state_next = S_HOLD;
          end
        end
      end

      S_HOLD: begin
        emit.vld     = 1'b1;
        emit.outcome = lgq_pkg::OUT_REFUSED;
        state_next   = S_FIN;
        r_next       = '0;
        w_next       = '0;
        copy_next    = 1'b0;
        newly_next   = 1'b0;
        pass_rm_next = 1'b0;
        case (kind_q)
          lgq_pkg::K_LOCK: begin
            if (mode_ok && h.status == lgq_pkg::ST_IDLE) begin
              if ((lgq_pkg::conflict_mask(mode_q) & gmask) != '0 ||
                  (cfh == '0 && (lgq_pkg::conflict_mask(mode_q) & wmask) != '0)) begin
                if (32'(qlen) < REQUESTERS) begin
                  qwr_en   = 1'b1;
                  qwr_data = id_q;
                  if (front_q) begin
                    head_next = (head == '0) ? IW'(REQUESTERS - 1) : head - 1'b1;
                    qwr_addr  = head_next;
                  end else begin
                    qwr_addr = wrap(head, qlen);
                  end
                  qlen_next          = qlen + 1'b1;
                  hwr_en             = 1'b1;
                  hwr_data           = '{lgq_pkg::ST_WAITING, mode_q, cf_q};
                  waitc_next[mode_q] = waitc[mode_q] + 1'b1;
                  emit.outcome       = lgq_pkg::OUT_WAITING;
                end
              end else begin
                hwr_en             = 1'b1;
                hwr_data           = '{lgq_pkg::ST_GRANTED, mode_q, cf_q};
                grant_next[mode_q] = grant[mode_q] + 1'b1;
                cfh_next           = cfh + CW'(cf_q);
                emit.outcome       = lgq_pkg::OUT_GRANTED;
              end
            end
          end
          lgq_pkg::K_UNLOCK: begin
            if (h.status == lgq_pkg::ST_GRANTED) begin
              hwr_en          = 1'b1;
              hwr_data.status = lgq_pkg::ST_IDLE;
              if (grant[h.mode] != '0) grant_next[h.mode] = grant[h.mode] - 1'b1;
              if (h.cf && cfh != '0) cfh_next = cfh - 1'b1;
              emit.outcome = lgq_pkg::OUT_RELEASED;
              if (grant[h.mode] <= CW'(1)) state_next = S_QRD;
            end else if (h.status == lgq_pkg::ST_WAITING) begin
              hwr_en          = 1'b1;
              hwr_data.status = lgq_pkg::ST_IDLE;
              if (waitc[h.mode] != '0) waitc_next[h.mode] = waitc[h.mode] - 1'b1;
              emit.outcome = lgq_pkg::OUT_RELEASED;
              pass_rm_next = 1'b1;
              state_next   = S_QRD;
            end
          end
          lgq_pkg::K_DOWN: begin
            if (mode_ok && h.status == lgq_pkg::ST_GRANTED &&
                (lgq_pkg::conflict_mask(h.mode) | lgq_pkg::conflict_mask(mode_q)) ==
                lgq_pkg::conflict_mask(h.mode)) begin
              if (mode_q != h.mode) begin
                grant_next[mode_q] = grant[mode_q] + 1'b1;
                if (grant[h.mode] != '0) grant_next[h.mode] = grant[h.mode] - 1'b1;
              end
              hwr_en        = 1'b1;
              hwr_data.mode = mode_q;
              emit.outcome  = lgq_pkg::OUT_DOWNGRADED;
              state_next    = S_QRD;
            end
          end
          default: begin
          end
        endcase
      end

      S_QRD: begin
        if (r == qlen) begin
          qlen_next = w;
          if (pass_rm) begin
            pass_rm_next = 1'b0;
            r_next       = '0;
            w_next       = '0;
          end else begin
            state_next = S_FIN;
          end
        end else if (copy && r == w) begin
          state_next = S_FIN;
        end else begin
          qrd_en     = 1'b1;
          state_next = S_QDAT;
        end
      end

      S_QDAT: begin
        state_next = S_QRD;
        if (copy || (pass_rm && qrd_data != id_q)) begin
          qwr_en = 1'b1;
          w_next = w + 1'b1;
          r_next = r + 1'b1;
        end else if (pass_rm) begin
          r_next = r + 1'b1;
        end else begin
          qid_next   = qrd_data;
          hrd_en     = 1'b1;
          hrd_addr   = IW'(qrd_data);
          state_next = S_HDAT;
        end
      end

      S_HDAT: begin
        if ((lgq_pkg::conflict_mask(h.mode) & gmask) != '0) begin
          state_next = S_QRD;
          if (w == '0 && !newly) begin
            copy_next = 1'b1;
          end else begin
            qwr_en   = 1'b1;
            qwr_data = qid;
            w_next   = w + 1'b1;
            r_next   = r + 1'b1;
          end
        end else if (ostat.out_free) begin
          hwr_en          = 1'b1;
          hwr_addr        = IW'(qid);
          hwr_data.status = lgq_pkg::ST_GRANTED;
          if (waitc[h.mode] != '0) waitc_next[h.mode] = waitc[h.mode] - 1'b1;
          grant_next[h.mode] = grant[h.mode] + 1'b1;
          if (h.cf) begin
            if (cfh == '0) newly_next = 1'b1;
            cfh_next = cfh + 1'b1;
          end
          emit.vld     = 1'b1;
          emit.id      = qid;
          emit.outcome = lgq_pkg::OUT_GRANTED;
          r_next       = r + 1'b1;
          if (h.mode == lgq_pkg::MODE_X) copy_next = 1'b1;
          state_next = S_QRD;
        end
      end

      S_FIN: begin
        if (ostat.out_free) begin
          flush      = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      qlen  <= '0;
      cfh   <= '0;
      for (int i = 0; i < lgq_pkg::MODES; i++) begin
        grant[i] <= '0;
        waitc[i] <= '0;
      end
    end else begin
      state <= state_next;
      head  <= head_next;
      qlen  <= qlen_next;
      cfh   <= cfh_next;
      grant <= grant_next;
      waitc <= waitc_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_q  <= kind_next;
    id_q    <= id_next;
    mode_q  <= mode_next;
    front_q <= front_next;
    cf_q    <= cf_next;
    r       <= r_next;
    w       <= w_next;
    pass_rm <= pass_rm_next;
    copy    <= copy_next;
    newly   <= newly_next;
    qid     <= qid_next;
  end

  lgq_holder_mem #(.DEPTH(REQUESTERS), .IW(IW)) u_holder (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (hrd_en),
    .rd_addr (hrd_addr),
    .rd_data (h),
    .wr_en   (hwr_en),
    .wr_addr (hwr_addr),
    .wr_data (hwr_data)
  );

  lgq_queue_mem #(.DEPTH(REQUESTERS), .IW(IW)) u_queue (
    .clk     (clk),
    .rd_en   (qrd_en),
    .rd_addr (qrd_addr),
    .rd_data (qrd_data),
    .wr_en   (qwr_en),
    .wr_addr (qwr_addr),
    .wr_data (qwr_data)
  );

  lgq_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .flush    (flush),
    .stat     (ostat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  logic [CW+2:0] wait_sum;
  always_comb begin
    wait_sum = '0;
    for (int i = 0; i < lgq_pkg::MODES; i++) wait_sum = wait_sum + (CW+3)'(waitc[i]);
  end

  a_qlen_bound: assert property (@(posedge clk) disable iff (rst)
    32'(qlen) <= REQUESTERS)
    else $error("queue length beyond depth");

  a_wait_sum: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> wait_sum == (CW+3)'(qlen))
    else $error("wait counts disagree with queue length");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ostat.pend_valid)
    else $error("held request left over at idle");

  a_ptr_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_QRD || state == S_QDAT || state == S_HDAT) |-> w <= r)
    else $error("queue write pointer passed read pointer");

endmodule
